>>> rtl/xtea_pkg.sv
package xtea_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int HALF_ROUNDS = 2 * ROUND_COUNT;

    localparam logic [31:0] DELTA = 32'h9e3779b9;

    localparam int WORD_W    = 64;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_START = 2'd2;

    // One slot of the round chain: the two halves travel swapped each half-round.
    typedef struct packed {
        logic              valid;
        logic              pass;
        logic [WORD_W-1:0] word;
        logic [31:0]       p;
        logic [31:0]       q;
    } t_stage;

    // Running sum seen by half-round h (even: before the add of DELTA, odd: after).
    function automatic logic [31:0] half_sum(input int h);
        logic [31:0] r;
        r = 32'((h >> 1) + (h & 1));
        return r * DELTA;
    endfunction

    function automatic logic [1:0] half_key(input int h);
        logic [31:0] s;
        s = half_sum(h);
        if (h[0]) begin
            return s[12:11];
        end else begin
            return s[1:0];
        end
    endfunction

endpackage

>>> rtl/xtea_if.sv
interface xtea_in_if;
    logic                         valid;
    logic                         ready;
    logic [xtea_pkg::WORD_W-1:0]  data_word;
    logic [xtea_pkg::COUNT_W-1:0] valid_bytes;
    logic                         section_start;

    modport source (output valid, data_word, valid_bytes, section_start, input ready);
    modport sink   (input valid, data_word, valid_bytes, section_start, output ready);
endinterface

interface xtea_out_if;
    logic                        valid;
    logic                        ready;
    logic [xtea_pkg::WORD_W-1:0] out_word;

    modport source (output valid, out_word, input ready);
    modport sink   (input valid, out_word, output ready);
endinterface

>>> rtl/xtea_ctr_stream_cipher.sv
// Channel  | Dir | Fields                                     | Transfer
// i_in     | in  | data_word, valid_bytes, section_start      | valid && ready
// o_out    | out | out_word                                   | valid && ready
// i_cfg_*  | in  | idx 0 key_high, 1 key_low, 2 counter_start | i_cfg_we
//
// One word per cycle when nothing stalls; a word passes through the 64 half-round cells,
// the first loaded at its transfer, and then through the output register.
// Synchronous active-low reset clears the counter, the key and counter-start registers and all valid bits.
// A stalled output holds its word; the chain keeps moving while its tail is empty,
// so new words are taken until a finished word would have nowhere to go.
module xtea_ctr_stream_cipher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    xtea_in_if.sink                          i_in,
    xtea_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [xtea_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [xtea_pkg::CFG_W-1:0]       i_cfg_data
);
    import xtea_pkg::*;

    logic [63:0]       r_key_high;
    logic [63:0]       r_key_low;
    logic [63:0]       r_ctr_start;
    logic [63:0]       r_ctr;
    logic [63:0]       n_ctr;
    logic [63:0]       ctr_use;
    logic              full;
    logic              accept;
    logic              en;
    logic              load_out;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [31:0]       kw [4];
    t_stage            stage [HALF_ROUNDS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_ctr_start <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HIGH:      r_key_high  <= i_cfg_data;
                CFG_KEY_LOW:       r_key_low   <= i_cfg_data;
                CFG_COUNTER_START: r_ctr_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign kw[0] = r_key_high[63:32];
    assign kw[1] = r_key_high[31:0];
    assign kw[2] = r_key_low[63:32];
    assign kw[3] = r_key_low[31:0];

    assign load_out = !r_out_valid || o_out.ready;
    assign en       = load_out || !stage[HALF_ROUNDS].valid;
    assign accept   = i_in.valid && en;
    assign i_in.ready = en;

    // valid_bytes of 8 and above counts as a full word
    assign full    = i_in.valid_bytes[COUNT_W-1];
    assign ctr_use = i_in.section_start ? r_ctr_start : r_ctr;
    assign n_ctr   = full ? ctr_use + 64'd1 : ctr_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
        end else if (accept) begin
            r_ctr <= n_ctr;
        end
    end

    assign stage[0] = '{valid: accept, pass: !full, word: i_in.data_word,
                        p: ctr_use[63:32], q: ctr_use[31:0]};

    for (genvar g = 0; g < HALF_ROUNDS; g++) begin : g_cell
        logic [31:0] sk;
        assign sk = half_sum(g) + kw[half_key(g)];
        xtea_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_sk    (sk),
            .i_stage (stage[g]),
            .o_stage (stage[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= stage[HALF_ROUNDS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_word <= stage[HALF_ROUNDS].pass ? stage[HALF_ROUNDS].word
                        : stage[HALF_ROUNDS].word
                          ^ {stage[HALF_ROUNDS].p, stage[HALF_ROUNDS].q};
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_word = r_out_word;

endmodule

>>> rtl/xtea_cell.sv
module xtea_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [31:0]      i_sk,
    input  xtea_pkg::t_stage i_stage,
    output xtea_pkg::t_stage o_stage
);
    import xtea_pkg::*;

    logic [31:0]       mix;
    logic              r_valid;
    logic              r_pass;
    logic [WORD_W-1:0] r_word;
    logic [31:0]       r_p;
    logic [31:0]       r_q;
    logic [31:0]       n_q;

    always_comb begin
        mix = (((i_stage.q << 4) ^ (i_stage.q >> 5)) + i_stage.q) ^ i_sk;
        n_q = i_stage.p + mix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    // halves swap so the next cell always updates p from q
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pass <= i_stage.pass;
            r_word <= i_stage.word;
            r_p    <= i_stage.q;
            r_q    <= n_q;
        end
    end

    assign o_stage = '{valid: r_valid, pass: r_pass, word: r_word, p: r_p, q: r_q};

endmodule

>>> rtl/xtea_chk.sv
module xtea_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_word
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped under stall");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_word))
        else $error("output word changed under stall");

endmodule

bind xtea_ctr_stream_cipher xtea_chk u_xtea_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.out_word)
);

>>> sim/tb_xtea_ctr_stream_cipher.sv
module tb_xtea_ctr_stream_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    import xtea_pkg::*;

    localparam int          LIMIT_CYCLES    = 200000;
    localparam int          DRAIN_CYCLES    = 100;
    localparam int          MAX_PRINTED     = 30;
    localparam logic [3:0]  FULL_WORD_BYTES = 4'd8;
    localparam logic [63:0] ALL_ONES        = {64{1'b1}};

    // Keystream/counter predictor plus the queue of words still owed by the block.
    class xtea_ctr_scoreboard;
        bit [63:0] key_hi;
        bit [63:0] key_lo;
        bit [63:0] ctr_load;
        bit [63:0] ctr;
        bit [63:0] owed_words[$];

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [63:0] val);
            case (idx)
                CFG_KEY_HIGH:      key_hi = val;
                CFG_KEY_LOW:       key_lo = val;
                CFG_COUNTER_START: ctr_load = val;
                default: ;
            endcase
        endfunction

        function bit [63:0] keystream(bit [63:0] blk);
            bit [31:0] y;
            bit [31:0] z;
            bit [31:0] s;
            bit [31:0] kw[4];
            y = blk[63:32];
            z = blk[31:0];
            s = '0;
            kw[0] = key_hi[63:32];
            kw[1] = key_hi[31:0];
            kw[2] = key_lo[63:32];
            kw[3] = key_lo[31:0];
            for (int r = 0; r < ROUND_COUNT; r++) begin
                y += (((z << 4) ^ (z >> 5)) + z) ^ (s + kw[s[1:0]]);
                s += DELTA;
                z += (((y << 4) ^ (y >> 5)) + y) ^ (s + kw[s[12:11]]);
            end
            return {y, z};
        endfunction

        function void note_input(bit [63:0] word, bit [3:0] nbytes, bit start);
            if (start) begin
                ctr = ctr_load;
            end
            // partial tail passes through and does not advance the counter
            if (nbytes >= FULL_WORD_BYTES) begin
                owed_words.push_back(word ^ keystream(ctr));
                ctr = ctr + 64'd1;
            end else begin
                owed_words.push_back(word);
            end
        endfunction

        function string check_result(bit [63:0] got);
            bit [63:0] want;
            if (owed_words.size() == 0) begin
                return $sformatf("unexpected out_word %016h", got);
            end
            want = owed_words.pop_front();
            if (got !== want) begin
                return $sformatf("out_word %016h, expected %016h", got, want);
            end
            return "";
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    int err_count = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int rx_hold_len = 0;

    xtea_ctr_scoreboard sb = new();

    xtea_in_if  in_ch();
    xtea_out_if out_ch();

    xtea_ctr_stream_cipher dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // transfers are sampled on pre-edge values, same as the block sees them
    always @(posedge clk) begin
        string msg;
        if (rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_input(in_ch.data_word, in_ch.valid_bytes, in_ch.section_start);
        end
        if (rst_n && out_ch.valid && out_ch.ready) begin
            msg = sb.check_result(out_ch.out_word);
            if (msg != "") begin
                report_mismatch(msg);
            end
        end
    end

    // output side back-pressure; a requested hold is counted down here
    initial begin
        int stall;
        int hold_left;
        stall = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_len > 0) begin
                hold_left = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else if (rx_calm) begin
                out_ch.ready <= 1'b1;
            end else begin
                stall = gap_len();
                if (stall == 0) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    stall--;
                end
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb_xtea_ctr_stream_cipher: done, errors");
        $finish;
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic load_config(logic [63:0] khi, logic [63:0] klo, logic [63:0] cstart);
        cfg_write(CFG_KEY_HIGH, khi);
        cfg_write(CFG_KEY_LOW, klo);
        cfg_write(CFG_COUNTER_START, cstart);
    endtask

    // offers one word and returns at the edge of its transfer, or after a random gap with valid dropped
    task automatic put_word(logic [63:0] w, logic [3:0] nb, logic st);
        int gap;
        in_ch.valid         <= 1'b1;
        in_ch.data_word     <= w;
        in_ch.valid_bytes   <= nb;
        in_ch.section_start <= st;
        do @(posedge clk); while (!in_ch.ready);
        gap = tx_calm ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one edge first so the last transfer is already noted by the scoreboard
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_words.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_words(int n);
        logic [63:0] w;
        logic [3:0]  nb;
        int          r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                w = '0;
            end else if (r < 10) begin
                w = ALL_ONES;
            end else begin
                w = rand64();
            end
            nb = ($urandom_range(0, 99) < 70) ? FULL_WORD_BYTES : 4'($urandom_range(0, 15));
            put_word(w, nb, $urandom_range(0, 15) == 0);
        end
        drain();
    endtask

    initial begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.data_word     <= '0;
        in_ch.valid_bytes   <= '0;
        in_ch.section_start <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset-value keys and counter
        put_word('0, FULL_WORD_BYTES, 1'b0);
        put_word(ALL_ONES, FULL_WORD_BYTES, 1'b1);
        put_word(64'h0123_4567_89ab_cdef, 4'd7, 1'b0);
        put_word(ALL_ONES, 4'd0, 1'b0);
        drain();

        // all-ones key, counter set just below the wrap
        load_config(ALL_ONES, ALL_ONES, 64'hffff_ffff_ffff_fffe);
        put_word(rand64(), FULL_WORD_BYTES, 1'b1);
        put_word(rand64(), FULL_WORD_BYTES, 1'b0);
        put_word(rand64(), 4'd15, 1'b0);
        put_word(rand64(), 4'd9, 1'b0);
        put_word(rand64(), 4'd3, 1'b1);
        put_word(rand64(), FULL_WORD_BYTES, 1'b0);
        put_word(rand64(), 4'd1, 1'b0);
        put_word('0, 4'd12, 1'b0);
        put_word(ALL_ONES, FULL_WORD_BYTES, 1'b1);
        drain();

        load_config(rand64(), '0, '0);
        random_words(110);

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        load_config(rand64(), rand64(), rand64());
        random_words(100);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // output held off long enough for the round chain to fill and stall input
        load_config(rand64(), rand64(), rand64());
        rx_hold_len = 400;
        random_words(120);

        load_config('0, rand64(), 64'hffff_ffff_ffff_fffc);
        random_words(100);

        load_config(rand64(), rand64(), rand64());
        random_words(100);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("tb_xtea_ctr_stream_cipher: done, clean");
        end else begin
            $display("tb_xtea_ctr_stream_cipher: done, errors");
        end
        $finish;
    end

endmodule
